[hdl/xmr_pkg.sv]
package xmr_pkg;

  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned BLK_CNT_W   = 25;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned BLK_SHIFT   = $clog2(BLOCK_BYTES);

  localparam logic [15:0]          CRC_POLY   = 16'h8005;
  localparam logic [BLK_CNT_W-1:0] BLOCKS_MAX = {BLK_CNT_W{1'b1}};

  // line and reply characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_SUB = 8'h1A;
  localparam logic [7:0] CH_C   = 8'h43;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // out_kind codes
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // verdict codes
  localparam logic [1:0] VD_NONE   = 2'd0;
  localparam logic [1:0] VD_ACCEPT = 2'd1;
  localparam logic [1:0] VD_REJECT = 2'd2;
  localparam logic [1:0] VD_FINISH = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_BLK,
    PH_COMP,
    PH_DATA,
    PH_CHK_HI,
    PH_CHK_LO
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] line_byte;
  } in_item_t;

  typedef struct packed {
    logic               out_kind;
    logic [7:0]         out_byte;
    logic [1:0]         verdict;
    logic [7:0]         final_length;
    logic [TOTAL_W-1:0] total_bytes;
  } out_item_t;

  // CRC-16, MSB first, one byte per call
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[hdl/xmodem_receiver.sv]
// XModem receiver, 128-byte blocks, sum or CRC-16 check.
// Input channel (in_valid / in_stall / in_data): one transaction per line
//   byte, or a start command that answers C (CRC mode) or NAK (sum mode).
// Output channel (out_valid / out_stall / out_data): at most one result per
//   input transaction: C/NAK on start, each data byte as it arrives, the
//   block ACK/NAK on the last check byte, ACK with final length, total on EOT.
// cfg_we / cfg_wdata write crc_mode (reset 1); write only while idle.
// Throughput: one transaction per cycle while out_stall is low. The byte-wide
//   CRC update, the sum and the counters all sit between the input register
//   and the result register.
// Reset: receiver idle, line bytes ignored until a start command; both
//   pipeline registers empty.
// When the receiver stalls, the result register holds and the input register
//   keeps one more transaction; after that in_stall rises. Transactions that
//   produce no result also wait for a free result slot.
module xmodem_receiver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  xmr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xmr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import xmr_pkg::*;

  logic       crc_mode_r;
  logic       crc_mode_nxt;
  logic       item_valid;
  logic       res_space;
  logic       advance;
  in_item_t   item;
  out_item_t  res;
  logic       res_valid;

  // config register
  always_comb begin
    crc_mode_nxt = cfg_we ? cfg_wdata : crc_mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_mode_r <= 1'b1;
    end else begin
      crc_mode_r <= crc_mode_nxt;
    end
  end

  // item moves from the input register into the core when the result slot is free
  assign advance = item_valid && res_space;

  xmr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  xmr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .crc_mode  (crc_mode_r),
    .fire      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  xmr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .space     (res_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hdl/xmr_in_stage.sv]
module xmr_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  xmr_pkg::in_item_t  in_data,
  input  logic               advance,
  output logic               item_valid,
  output xmr_pkg::in_item_t  item
);
  import xmr_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // hold while the register is full and the item cannot move on
  assign in_stall = valid_r && !advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && !in_stall) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[hdl/xmr_core.sv]
module xmr_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               crc_mode,
  input  logic               fire,
  input  xmr_pkg::in_item_t  item,
  output logic               res_valid,
  output xmr_pkg::out_item_t res
);
  import xmr_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [7:0]           expected_block_r, expected_block_nxt;
  logic                 header_good_r, header_good_nxt;
  logic [IDX_W-1:0]     byte_index_r, byte_index_nxt;
  logic [15:0]          crc_acc_r, crc_acc_nxt;
  logic [7:0]           sum_acc_r, sum_acc_nxt;
  logic [7:0]           check_high_r, check_high_nxt;
  logic [IDX_W-1:0]     cur_nonsub_len_r, cur_nonsub_len_nxt;
  logic [IDX_W-1:0]     last_block_len_r, last_block_len_nxt;
  logic [BLK_CNT_W-1:0] blocks_accepted_r, blocks_accepted_nxt;

  logic [7:0]           b;
  logic                 is_byte;
  logic [IDX_W-1:0]     idx_inc;
  logic                 chk_ok;
  logic                 verdict_now;
  logic                 blk_ok;
  logic [TOTAL_W-1:0]   total;
  logic [BLK_CNT_W-1:0] blocks_m1;

  assign b       = item.line_byte;
  assign is_byte = fire && (item.command == CMD_BYTE);
  assign idx_inc = byte_index_r + IDX_W'(1);

  assign chk_ok = crc_mode ? ({check_high_r, b} == crc_acc_r) : (b == sum_acc_r);
  assign verdict_now = is_byte &&
                       (((phase_r == PH_CHK_HI) && !crc_mode) || (phase_r == PH_CHK_LO));
  assign blk_ok = header_good_r && chk_ok;

  // (blocks - 1) * BLOCK_BYTES + last length; cannot pass 32 bits
  assign blocks_m1 = blocks_accepted_r - BLK_CNT_W'(1);
  assign total = (blocks_accepted_r == '0) ? '0 :
                 ({blocks_m1, BLK_SHIFT'(0)} + TOTAL_W'(last_block_len_r));

  // next state
  always_comb begin
    phase_nxt           = phase_r;
    expected_block_nxt  = expected_block_r;
    header_good_nxt     = header_good_r;
    byte_index_nxt      = byte_index_r;
    crc_acc_nxt         = crc_acc_r;
    sum_acc_nxt         = sum_acc_r;
    check_high_nxt      = check_high_r;
    cur_nonsub_len_nxt  = cur_nonsub_len_r;
    last_block_len_nxt  = last_block_len_r;
    blocks_accepted_nxt = blocks_accepted_r;
    if (fire && (item.command == CMD_START)) begin
      phase_nxt           = PH_WAIT;
      expected_block_nxt  = 8'd1;
      header_good_nxt     = 1'b0;
      byte_index_nxt      = '0;
      crc_acc_nxt         = '0;
      sum_acc_nxt         = '0;
      check_high_nxt      = '0;
      cur_nonsub_len_nxt  = '0;
      last_block_len_nxt  = '0;
      blocks_accepted_nxt = '0;
    end else if (is_byte) begin
      case (phase_r)
        PH_WAIT: begin
          if (b == CH_SOH) begin
            header_good_nxt    = 1'b1;
            byte_index_nxt     = '0;
            crc_acc_nxt        = '0;
            sum_acc_nxt        = '0;
            cur_nonsub_len_nxt = '0;
            phase_nxt          = PH_BLK;
          end else if (b == CH_EOT) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_BLK: begin
          if (b != expected_block_r) header_good_nxt = 1'b0;
          phase_nxt = PH_COMP;
        end
        PH_COMP: begin
          if (b != ~expected_block_r) header_good_nxt = 1'b0;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          crc_acc_nxt    = crc_update(crc_acc_r, b);
          sum_acc_nxt    = sum_acc_r + b;
          byte_index_nxt = idx_inc;
          if (b != CH_SUB) cur_nonsub_len_nxt = idx_inc;
          if (idx_inc >= IDX_W'(BLOCK_BYTES)) phase_nxt = PH_CHK_HI;
        end
        PH_CHK_HI, PH_CHK_LO: begin
          if (verdict_now) begin
            if (blk_ok) begin
              expected_block_nxt = expected_block_r + 8'd1;
              if (blocks_accepted_r != BLOCKS_MAX) begin
                blocks_accepted_nxt = blocks_accepted_r + BLK_CNT_W'(1);
              end
              last_block_len_nxt = cur_nonsub_len_r;
            end
            phase_nxt = PH_WAIT;
          end else begin
            check_high_nxt = b;
            phase_nxt      = PH_CHK_LO;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (fire && (item.command == CMD_START)) begin
      res_valid    = 1'b1;
      res.out_kind = KIND_REPLY;
      res.out_byte = crc_mode ? CH_C : CH_NAK;
    end else if (is_byte) begin
      case (phase_r)
        PH_WAIT: begin
          if (b == CH_EOT) begin
            res_valid        = 1'b1;
            res.out_kind     = KIND_REPLY;
            res.out_byte     = CH_ACK;
            res.verdict      = VD_FINISH;
            res.final_length = last_block_len_r;
            res.total_bytes  = total;
          end
        end
        PH_DATA: begin
          res_valid    = 1'b1;
          res.out_kind = KIND_DATA;
          res.out_byte = b;
        end
        PH_CHK_HI, PH_CHK_LO: begin
          if (verdict_now) begin
            res_valid    = 1'b1;
            res.out_kind = KIND_REPLY;
            res.out_byte = blk_ok ? CH_ACK : CH_NAK;
            res.verdict  = blk_ok ? VD_ACCEPT : VD_REJECT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_IDLE;
      expected_block_r  <= 8'd1;
      header_good_r     <= 1'b0;
      byte_index_r      <= '0;
      crc_acc_r         <= '0;
      sum_acc_r         <= '0;
      check_high_r      <= '0;
      cur_nonsub_len_r  <= '0;
      last_block_len_r  <= '0;
      blocks_accepted_r <= '0;
    end else begin
      phase_r           <= phase_nxt;
      expected_block_r  <= expected_block_nxt;
      header_good_r     <= header_good_nxt;
      byte_index_r      <= byte_index_nxt;
      crc_acc_r         <= crc_acc_nxt;
      sum_acc_r         <= sum_acc_nxt;
      check_high_r      <= check_high_nxt;
      cur_nonsub_len_r  <= cur_nonsub_len_nxt;
      last_block_len_r  <= last_block_len_nxt;
      blocks_accepted_r <= blocks_accepted_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= IDX_W'(BLOCK_BYTES))
    else $error("byte index past block size");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_nonsub_len_r <= byte_index_r)
    else $error("non-SUB length past byte index");

  a_data_out: assert property (@(posedge clk) disable iff (!rst_n)
    (is_byte && (phase_r == PH_DATA)) |-> (res_valid && (res.out_kind == KIND_DATA)))
    else $error("data byte not passed on");

  a_ack_count: assert property (@(posedge clk) disable iff (!rst_n)
    (verdict_now && blk_ok) |=> (expected_block_r == $past(expected_block_r) + 8'd1))
    else $error("accepted block did not advance block number");

  a_last_len: assert property (@(posedge clk) disable iff (!rst_n)
    last_block_len_r <= IDX_W'(BLOCK_BYTES))
    else $error("last block length out of range");

endmodule

[hdl/xmr_out_stage.sv]
module xmr_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  xmr_pkg::out_item_t res,
  output logic               space,
  output logic               out_valid,
  input  logic               out_stall,
  output xmr_pkg::out_item_t out_data
);
  import xmr_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign space = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
